// File: rtl/core/vcdv_pkg.sv
// types, constants and character functions shared by the check digit validator
package vcdv_pkg;

    // one input item: ascii character and final-character flag
    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic        format_ok;
        logic        check_ok;
        logic [10:0] model_year;
    } t_out_item;

    // transliteration lookup result
    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_xlit;

    localparam logic [4:0] VIN_LEN   = 5'd17;
    localparam logic [4:0] COUNT_SAT = 5'd18;
    localparam logic [4:0] CHECK_POS = 5'd8;
    localparam logic [4:0] YEAR_POS  = 5'd9;
    localparam logic [3:0] MOD_BASE  = 4'd11;
    localparam logic [3:0] MOD_TEN   = 4'd10;

    localparam logic [7:0] CH_0  = "0";
    localparam logic [7:0] CH_1  = "1";
    localparam logic [7:0] CH_9  = "9";
    localparam logic [7:0] CH_A  = "A";
    localparam logic [7:0] CH_H  = "H";
    localparam logic [7:0] CH_J  = "J";
    localparam logic [7:0] CH_K  = "K";
    localparam logic [7:0] CH_L  = "L";
    localparam logic [7:0] CH_N  = "N";
    localparam logic [7:0] CH_P  = "P";
    localparam logic [7:0] CH_R  = "R";
    localparam logic [7:0] CH_S  = "S";
    localparam logic [7:0] CH_T  = "T";
    localparam logic [7:0] CH_V  = "V";
    localparam logic [7:0] CH_X  = "X";
    localparam logic [7:0] CH_Y  = "Y";
    localparam logic [7:0] CH_Z  = "Z";
    localparam logic [7:0] CH_LA = "a";
    localparam logic [7:0] CH_LZ = "z";
    localparam logic [7:0] CASE_OFS = 8'd32;

    localparam logic [10:0] YEAR_A    = 11'd2010;
    localparam logic [10:0] YEAR_J    = 11'd2018;
    localparam logic [10:0] YEAR_P    = 11'd2023;
    localparam logic [10:0] YEAR_R    = 11'd2024;
    localparam logic [10:0] YEAR_S    = 11'd1995;
    localparam logic [10:0] YEAR_T    = 11'd1996;
    localparam logic [10:0] YEAR_V    = 11'd1997;
    localparam logic [10:0] YEAR_1    = 11'd2001;
    localparam logic [10:0] YEAR_NONE = 11'd0;

    function automatic logic [7:0] f_upper(input logic [7:0] c);
        if (c >= CH_LA && c <= CH_LZ) return c - CASE_OFS;
        return c;
    endfunction

    function automatic t_xlit f_translit(input logic [7:0] c);
        t_xlit x;
        x.ok  = 1'b1;
        x.val = 4'd0;
        if (c >= CH_0 && c <= CH_9)      x.val = 4'(c - CH_0);
        else if (c >= CH_A && c <= CH_H) x.val = 4'(c - CH_A + 8'd1);
        else if (c == CH_J)              x.val = 4'd1;
        else if (c == CH_K)              x.val = 4'd2;
        else if (c >= CH_L && c <= CH_N) x.val = 4'(c - CH_L + 8'd3);
        else if (c == CH_P)              x.val = 4'd7;
        else if (c == CH_R)              x.val = 4'd9;
        else if (c >= CH_S && c <= CH_Z) x.val = 4'(c - CH_S + 8'd2);
        else                             x.ok  = 1'b0;
        return x;
    endfunction

    function automatic logic [3:0] f_weight(input logic [4:0] pos);
        logic [3:0] w;
        case (pos)
            5'd0, 5'd10:  w = 4'd8;
            5'd1, 5'd11:  w = 4'd7;
            5'd2, 5'd12:  w = 4'd6;
            5'd3, 5'd13:  w = 4'd5;
            5'd4, 5'd14:  w = 4'd4;
            5'd5, 5'd15:  w = 4'd3;
            5'd6, 5'd16:  w = 4'd2;
            5'd7:         w = 4'd10;
            5'd9:         w = 4'd9;
            default:      w = 4'd0;
        endcase
        return w;
    endfunction

    // remainder mod 11 of a product up to 90, restoring steps of 88, 44, 22, 11
    function automatic logic [3:0] f_mod11_small(input logic [6:0] p);
        logic [6:0] r;
        r = p;
        if (r >= 7'd88) r = r - 7'd88;
        if (r >= 7'd44) r = r - 7'd44;
        if (r >= 7'd22) r = r - 7'd22;
        if (r >= 7'd11) r = r - 7'd11;
        return r[3:0];
    endfunction

    function automatic logic [3:0] f_add_mod11(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] s;
        s = 5'(a) + 5'(b);
        if (s >= 5'(MOD_BASE)) s = s - 5'(MOD_BASE);
        return s[3:0];
    endfunction

    function automatic logic [7:0] f_check_char(input logic [3:0] r);
        if (r == MOD_TEN) return CH_X;
        return CH_0 + 8'(r);
    endfunction

    function automatic logic [10:0] f_year(input logic [7:0] c);
        if (c >= CH_A && c <= CH_H) return YEAR_A + 11'(c - CH_A);
        if (c >= CH_J && c <= CH_N) return YEAR_J + 11'(c - CH_J);
        if (c == CH_P)              return YEAR_P;
        if (c == CH_R)              return YEAR_R;
        if (c == CH_S)              return YEAR_S;
        if (c == CH_T)              return YEAR_T;
        if (c >= CH_V && c <= CH_Y) return YEAR_V + 11'(c - CH_V);
        if (c >= CH_1 && c <= CH_9) return YEAR_1 + 11'(c - CH_1);
        return YEAR_NONE;
    endfunction

endpackage

// File: rtl/core/vcdv_stream_if.sv
// valid/ready stream channel carrying one payload item
interface vcdv_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/vcdv_in_stage.sv
// input register: captures each item and folds it to upper case
module vcdv_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vcdv_stream_if.sink   i_in,
    vcdv_stream_if.source o_mid
);
    import vcdv_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // refill when empty or when the held item moves on
    assign i_in.ready = !r_valid || o_mid.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_item.char_code <= f_upper(i_in.data.char_code);
            r_item.is_last   <= i_in.data.is_last;
        end
    end

    assign o_mid.valid = r_valid;
    assign o_mid.data  = r_item;
endmodule

// File: rtl/core/vcdv_accum.sv
// running position, residue and held characters; result register
module vcdv_accum (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vcdv_stream_if.sink   i_mid,
    vcdv_stream_if.source o_out
);
    import vcdv_pkg::*;

    logic [4:0] r_count;
    logic [3:0] r_sum;
    logic       r_bad;
    logic [7:0] r_check_char;
    logic [7:0] r_year_char;
    logic       r_out_valid;
    t_out_item  r_out;

    logic [4:0] n_count;
    logic [3:0] n_sum;
    logic       n_bad;
    logic [7:0] n_check_char;
    logic [7:0] n_year_char;
    t_out_item  n_out;
    t_xlit      w_xlit;
    logic [7:0] w_char;
    logic       w_take;

    assign i_mid.ready = !r_out_valid || o_out.ready;
    assign w_take      = i_mid.valid && i_mid.ready;
    assign w_char      = i_mid.data.char_code;

    always_comb begin
        n_count      = r_count;
        n_sum        = r_sum;
        n_bad        = r_bad;
        n_check_char = r_check_char;
        n_year_char  = r_year_char;
        w_xlit       = f_translit(w_char);
        if (r_count < VIN_LEN) begin
            if (!w_xlit.ok) begin
                n_bad = 1'b1;
            end else begin
                n_sum = f_add_mod11(r_sum,
                    f_mod11_small(7'(w_xlit.val * f_weight(r_count))));
            end
            if (r_count == CHECK_POS) n_check_char = w_char;
            if (r_count == YEAR_POS)  n_year_char  = w_char;
        end
        if (r_count < COUNT_SAT) n_count = r_count + 5'd1;

        n_out.format_ok  = (n_count == VIN_LEN) && !n_bad;
        n_out.check_ok   = n_out.format_ok && (n_check_char == f_check_char(n_sum));
        n_out.model_year = n_out.format_ok ? f_year(n_year_char) : YEAR_NONE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_sum        <= '0;
            r_bad        <= 1'b0;
            r_check_char <= '0;
            r_year_char  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_out.ready) r_out_valid <= 1'b0;
            if (w_take) begin
                if (i_mid.data.is_last) begin
                    r_count      <= '0;
                    r_sum        <= '0;
                    r_bad        <= 1'b0;
                    r_check_char <= '0;
                    r_year_char  <= '0;
                    r_out_valid  <= 1'b1;
                end else begin
                    r_count      <= n_count;
                    r_sum        <= n_sum;
                    r_bad        <= n_bad;
                    r_check_char <= n_check_char;
                    r_year_char  <= n_year_char;
                end
            end
        end
        if (w_take && i_mid.data.is_last) r_out <= n_out;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // identifier state restarts after every final character
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_mid.data.is_last) |=> (r_count == '0 && r_sum == '0 && !r_bad))
        else $error("state not cleared after final item");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_SAT)
        else $error("position count beyond saturation");

    a_residue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum < MOD_BASE)
        else $error("residue out of range");

    a_bad_format_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.format_ok) |-> (!r_out.check_ok && r_out.model_year == '0))
        else $error("bad format with nonzero check or year");
endmodule

// File: rtl/core/vin_check_digit_validator.sv
// top level of the vin check digit validator
// an accepted final character passes the input register, then the result register, before its result is on o_out
// throughput: one character item per cycle, sustained while o_out is taken
// characters that are not final give no result; state clears after each result
// reset: synchronous active-low i_rst_n empties both registers and clears state
module vin_check_digit_validator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    vcdv_stream_if.sink   i_in,
    vcdv_stream_if.source o_out
);
    import vcdv_pkg::*;

    // stage between the input register and the accumulator
    vcdv_stream_if #(.T(t_in_item)) mid_if ();

    // input register: upper-case folding of the character
    vcdv_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_mid   (mid_if.source)
    );

    // accumulator: position count, weighted residue mod 11, held characters
    // at positions 9 and 10, and the result register that feeds o_out
    vcdv_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mid   (mid_if.sink),
        .o_out   (o_out)
    );
endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the vin check digit validator
`timescale 1ns / 100ps

module tb;

    import vcdv_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 10;
    localparam int TOTAL_ITEMS  = 1550;
    localparam int PHASE2_AT    = 600;
    localparam int PHASE3_AT    = 1100;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_NS     = 4_000_000;

    // identifier layout
    localparam int ID_LEN    = 17;
    localparam int CNT_CAP   = 18;
    localparam int CHECK_IDX = 8;
    localparam int YEAR_IDX  = 9;
    localparam int MODULUS   = 11;

    localparam int POS_WEIGHT [ID_LEN] = '{8, 7, 6, 5, 4, 3, 2, 10, 0, 9, 8, 7, 6, 5, 4, 3, 2};

    // model year per letter code A..Z, zero where the letter is not a year code
    localparam int LETTER_YEAR [26] = '{
        2010, 2011, 2012, 2013, 2014, 2015, 2016, 2017, 0,
        2018, 2019, 2020, 2021, 2022, 0, 2023, 0, 2024,
        1995, 1996, 0, 1997, 1998, 1999, 2000, 0
    };

    // transliteration digit per letter A..Z, a dot marks a banned letter
    string letter_value = "12345678.12345.7.923456789";
    string legal_chars  = "0123456789ABCDEFGHJKLMNPRSTUVWXYZ";
    string banned_chars = "IOQioq";

    // directed identifiers; an underscore stands for a nul byte
    localparam int NDIR = 16;
    string dir_id [NDIR] = '{
        "00000000000000000",
        "11111111111111111",
        "99999999999999999",
        "A",
        "1234567890ABCDEF",
        "123456789ABCDEFGHJ",
        "1HGCM82633A00435I",
        "1M8GDM9AXKP042788",
        "1m8gdm9axkp042788",
        "ZZZZZZZZZZZZZZZZZ",
        "11111111XU1111111",
        "\3771111111111111111",
        "_111111111111111\200",
        "1111111111111111111111111111111111111111",
        "QQQQQQQQQOQQQQQQQ",
        "5YJSA1E26HF000337"
    };
    bit dir_typed [NDIR] = '{1, 1, 1, 1, 1, 1, 1, 0, 0, 1, 0, 1, 1, 1, 1, 0};
    t_out_item dir_want [NDIR] = '{
        '{1'b1, 1'b1, 11'd0},       // all zeros: sum 0, check 0, year code unknown
        '{1'b1, 1'b1, 11'd2001},    // all ones: sum 89, remainder 1
        '{1'b1, 1'b1, 11'd2009},    // all nines: largest sum 801, remainder 9
        '{1'b0, 1'b0, 11'd0},       // single character
        '{1'b0, 1'b0, 11'd0},       // one short
        '{1'b0, 1'b0, 11'd0},       // one too many
        '{1'b0, 1'b0, 11'd0},       // banned letter at the end
        '0,
        '0,
        '{1'b1, 1'b0, 11'd0},       // all Z: check wants 9, year code unknown
        '0,
        '{1'b0, 1'b0, 11'd0},       // top-half byte
        '{1'b0, 1'b0, 11'd0},       // nul and 0x80
        '{1'b0, 1'b0, 11'd0},       // count runs far past saturation
        '{1'b0, 1'b0, 11'd0},       // banned letters only
        '0
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    vcdv_stream_if #(.T(t_in_item))  in_ch ();
    vcdv_stream_if #(.T(t_out_item)) out_ch ();

    vin_check_digit_validator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state
    logic [4:0] seen_cnt;
    logic [9:0] wsum;
    logic       bad_seen;
    logic [7:0] check_chr;
    logic [7:0] year_chr;

    t_out_item expected_results [$];
    logic [7:0] vin_buf [$];

    int  n_errors    = 0;
    int  items_sent  = 0;
    int  snd_idle_pct = 12;
    int  rcv_idle_pct = 56;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= "a" && c <= "z") return c - 8'd32;
        return c;
    endfunction

    // transliteration digit of an upper-case character, -1 when not allowed
    function automatic int char_value(input logic [7:0] c);
        logic [7:0] d;
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c < "A" || c > "Z") return -1;
        d = letter_value[c - "A"];
        if (d == ".") return -1;
        return int'(d - "0");
    endfunction

    function automatic int year_for_code(input logic [7:0] c);
        if (c >= "1" && c <= "9") return 2000 + int'(c - "0");
        if (c >= "A" && c <= "Z") return LETTER_YEAR[c - "A"];
        return 0;
    endfunction

    function automatic void clear_vin_state();
        seen_cnt  = '0;
        wsum      = '0;
        bad_seen  = 1'b0;
        check_chr = '0;
        year_chr  = '0;
    endfunction

    // advance the predictor by one character, returns 1 when a result is due
    function automatic bit vin_take_char(input logic [7:0] c, input logic last,
                                         output t_out_item res);
        logic [7:0] cu;
        logic [7:0] want;
        int         v;
        int         rem;
        bit         fmt;
        cu  = upcase(c);
        res = '0;
        if (seen_cnt < ID_LEN) begin
            v = char_value(cu);
            if (v < 0)
                bad_seen = 1'b1;
            else
                wsum = 10'(int'(wsum) + v * POS_WEIGHT[seen_cnt]);
            if (seen_cnt == CHECK_IDX) check_chr = cu;
            if (seen_cnt == YEAR_IDX) year_chr = cu;
        end
        if (seen_cnt < CNT_CAP) seen_cnt = seen_cnt + 5'd1;
        if (!last) return 1'b0;
        fmt  = (seen_cnt == ID_LEN) && !bad_seen;
        rem  = int'(wsum) % MODULUS;
        want = (rem == 10) ? 8'("X") : 8'("0") + 8'(rem);
        res.format_ok  = fmt;
        res.check_ok   = fmt && (check_chr == want);
        res.model_year = fmt ? 11'(year_for_code(year_chr)) : 11'd0;
        clear_vin_state();
        return 1'b1;
    endfunction

    // offer one character, wait for it to be taken, then predict
    task automatic put_char(input logic [7:0] c, input logic last,
                            input bit typed, input t_out_item typed_res);
        t_out_item res;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{char_code: c, is_last: last};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (vin_take_char(c, last, res))
            expected_results.push_back(typed ? typed_res : res);
    endtask

    function automatic logic [7:0] legal_char();
        logic [7:0] ch;
        ch = legal_chars[$urandom_range(0, legal_chars.len() - 1)];
        // letters come in lower case now and then
        if (ch >= "A" && $urandom_range(0, 3) == 0) ch = ch + 8'd32;
        return ch;
    endfunction

    function automatic logic [7:0] bad_char();
        if ($urandom_range(0, 1) == 0)
            return banned_chars[$urandom_range(0, banned_chars.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // fill vin_buf with one identifier: mostly well formed, the rest broken
    function automatic void build_vin();
        int sum;
        int rem;
        int len;
        int kind;
        vin_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            for (int i = 0; i < ID_LEN; i++) vin_buf.push_back(legal_char());
            // most well-formed identifiers carry the right check character
            if ($urandom_range(0, 9) < 6) begin
                sum = 0;
                for (int i = 0; i < ID_LEN; i++)
                    sum += char_value(upcase(vin_buf[i])) * POS_WEIGHT[i];
                rem = sum % MODULUS;
                vin_buf[CHECK_IDX] = (rem == 10) ? 8'("X") : 8'("0") + 8'(rem);
                if (rem == 10 && $urandom_range(0, 1) == 1) vin_buf[CHECK_IDX] = "x";
            end
        end else if (kind < 84) begin
            // wrong length, legal characters
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 16) : $urandom_range(18, 40);
            if ($urandom_range(0, 1) == 0) len = ($urandom_range(0, 1) == 0) ? 16 : 18;
            for (int i = 0; i < len; i++) vin_buf.push_back(legal_char());
        end else if (kind < 93) begin
            // right length with a few disallowed characters
            for (int i = 0; i < ID_LEN; i++) vin_buf.push_back(legal_char());
            for (int i = $urandom_range(1, 3); i > 0; i--)
                vin_buf[$urandom_range(0, ID_LEN - 1)] = bad_char();
        end else begin
            // raw noise
            len = $urandom_range(1, 24);
            for (int i = 0; i < len; i++) vin_buf.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // stimulus
    initial begin
        logic [7:0] ch;
        int         n;
        clear_vin_state();
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed identifiers
        for (int r = 0; r < NDIR; r++) begin
            n = dir_id[r].len();
            for (int k = 0; k < n; k++) begin
                ch = dir_id[r][k];
                if (ch == "_") ch = 8'h00;
                put_char(ch, k == n - 1, dir_typed[r], dir_want[r]);
            end
        end

        // random identifiers, idling pattern changes with progress
        while (items_sent < TOTAL_ITEMS) begin
            if (items_sent < PHASE2_AT) begin
                snd_idle_pct = 12;
                rcv_idle_pct = 56;
            end else if (items_sent < PHASE3_AT) begin
                snd_idle_pct = 56;
                rcv_idle_pct = 12;
            end else begin
                // no idling from here; the sink holds off once to back up the block
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            build_vin();
            for (int k = 0; k < vin_buf.size(); k++)
                put_char(vin_buf[k], k == vin_buf.size() - 1, 1'b0, '0);
        end
        in_ch.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("** vin_check_digit_validator: PASSED **");
        else
            $display("** vin_check_digit_validator: FAILED **");
        $finish;
    end

    // result sink: random stalls plus one long hold-off once idling stops
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && items_sent >= PHASE3_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // compare each taken result with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got fmt=%0b chk=%0b year=%0d",
                         $time, out_ch.data.format_ok, out_ch.data.check_ok,
                         out_ch.data.model_year);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (out_ch.data.format_ok !== want.format_ok) begin
                    $display("%0t: format_ok expected %0b, got %0b",
                             $time, want.format_ok, out_ch.data.format_ok);
                    n_errors++;
                end
                if (out_ch.data.check_ok !== want.check_ok) begin
                    $display("%0t: check_ok expected %0b, got %0b",
                             $time, want.check_ok, out_ch.data.check_ok);
                    n_errors++;
                end
                if (out_ch.data.model_year !== want.model_year) begin
                    $display("%0t: model_year expected %0d, got %0d",
                             $time, want.model_year, out_ch.data.model_year);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    initial begin
        #(LIMIT_NS);
        $display("** vin_check_digit_validator: FAILED **");
        $finish;
    end

endmodule
